// File: src/bmg_pkg.sv
package bmg_pkg;

  // field widths
  localparam int UNIFORM_BITS  = 32;
  localparam int OUT_FRAC_BITS = 28;
  localparam int OUT_W         = OUT_FRAC_BITS + 4;
  localparam int TOP_W         = $clog2(UNIFORM_BITS);
  localparam int EXP_W         = $clog2(UNIFORM_BITS + 1);

  // fixed point constants
  localparam int          LOG_STEPS    = 56;
  localparam int          ROOT_STEPS   = 60;
  localparam int          TAYLOR_TERMS = 11;
  localparam logic [63:0] TWO_LN2_Q62  = 64'h58B9_0BFB_E8E7_BCD6;
  localparam logic [63:0] PI_Q61       = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] ONE_Q62      = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic [UNIFORM_BITS-1:0] uniform_a;
    logic [UNIFORM_BITS-1:0] uniform_b;
  } bmg_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_cos;
    logic signed [OUT_W-1:0] normal_sin;
    logic                    bad_input;
  } bmg_out_t;

  // data riding along the log and root chains
  typedef struct packed {
    logic             bad;
    logic [2:0]       oct;
    logic [61:0]      f;
    logic [EXP_W-1:0] expo;
  } bmg_front_t;

  typedef struct packed {
    logic        bad;
    logic [2:0]  oct;
    logic [63:0] r;
  } bmg_rad_t;

  typedef struct packed {
    bmg_rad_t    rad;
    logic [63:0] phi;
  } bmg_hside_t;

  typedef struct packed {
    bmg_rad_t    rad;
    logic [63:0] c;
  } bmg_sin_t;

  typedef struct packed {
    logic bad;
    logic neg_c;
    logic neg_s;
  } bmg_sign_t;

endpackage

// File: src/bmg_mul.sv
module bmg_mul #(
  parameter int SHIFT  = 62,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [63:0]       a_i,
  input  logic [63:0]       b_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [63:0]       prod_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [63:0]       pp00_q, pp01_q, pp10_q, pp11_q;
  logic [SIDE_W-1:0] side1_q, side2_q;
  logic              vld1_q, vld2_q;
  logic [127:0]      full;
  logic [63:0]       prod_q;

  // stage one: four 32x32 partial products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pp00_q  <= a_i[31:0]  * b_i[31:0];
    pp01_q  <= a_i[31:0]  * b_i[63:32];
    pp10_q  <= a_i[63:32] * b_i[31:0];
    pp11_q  <= a_i[63:32] * b_i[63:32];
    side1_q <= side_i;
  end

  // stage two: sum and take the shifted window
  assign full = {pp11_q, 64'd0} + ({64'd0, pp01_q} << 32) + ({64'd0, pp10_q} << 32)
              + {64'd0, pp00_q};

  always_ff @(posedge clk_i) begin
    prod_q  <= full[SHIFT+63:SHIFT];
    side2_q <= side1_q;
  end

  assign valid_o = vld2_q;
  assign prod_o  = prod_q;
  assign side_o  = side2_q;

endmodule

// File: src/bmg_log_cell.sv
module bmg_log_cell #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [63:0]       m_i,
  input  logic [55:0]       frac_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [63:0]       m_o,
  output logic [55:0]       frac_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [63:0]        sq;
  logic [SIDE_W+55:0] sq_side;
  logic               bit_one;

  // square the mantissa, q61
  bmg_mul #(.SHIFT(61), .SIDE_W(SIDE_W + 56)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .a_i     (m_i),
    .b_i     (m_i),
    .side_i  ({frac_i, side_i}),
    .valid_o (valid_o),
    .prod_o  (sq),
    .side_o  (sq_side)
  );

  // one log2 fraction bit, renormalize when the square reached two
  assign bit_one = sq[62];
  assign m_o     = bit_one ? (sq >> 1) : sq;
  assign frac_o  = {sq_side[SIDE_W+54:SIDE_W], bit_one};
  assign side_o  = sq_side[SIDE_W-1:0];

endmodule

// File: src/bmg_root_cell.sv
module bmg_root_cell #(
  parameter int IDX    = 59,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [63:0]       x_i,
  input  logic [63:0]       rem_i,
  input  logic [63:0]       root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [63:0]       x_o,
  output logic [63:0]       rem_o,
  output logic [63:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int LO = 2 * IDX - 56;

  logic [1:0]        pair;
  logic [63:0]       rem_n, trial;
  logic              valid_q;
  logic [63:0]       x_q, rem_q, root_q;
  logic [SIDE_W-1:0] side_q;

  // next pair of radicand bits, zero once past the lowest radicand bit
  generate
    if (LO >= 0) begin : g_pair
      assign pair = x_i[LO+1:LO];
    end else begin : g_zero
      assign pair = 2'b00;
    end
  endgenerate

  // one restoring step
  assign rem_n = {rem_i[61:0], pair};
  assign trial = {root_i[61:0], 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_i;
    side_q <= side_i;
    if (rem_n >= trial) begin
      rem_q  <= rem_n - trial;
      root_q <= {root_i[62:0], 1'b1};
    end else begin
      rem_q  <= rem_n;
      root_q <= {root_i[62:0], 1'b0};
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

  // remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rem_q <= {root_q[62:0], 1'b0}))
    else $error("root remainder out of bound");

endmodule

// File: src/bmg_trig_cell.sv
module bmg_trig_cell #(
  parameter int K      = 11,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [63:0]       p2_i,
  input  logic [63:0]       s_i,
  input  logic [63:0]       c_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [63:0]       p2_o,
  output logic [63:0]       s_o,
  output logic [63:0]       c_o,
  output logic [SIDE_W-1:0] side_o
);
  import bmg_pkg::*;

  localparam logic [63:0]  DS      = 64'(2 * K * (2 * K + 1));
  localparam logic [63:0]  DC      = 64'((2 * K - 1) * (2 * K));
  localparam logic [127:0] RS_FULL = (128'd1 << 64) / {64'd0, DS};
  localparam logic [127:0] RC_FULL = (128'd1 << 64) / {64'd0, DC};
  localparam logic [63:0]  RECIP_S = RS_FULL[63:0];
  localparam logic [63:0]  RECIP_C = RC_FULL[63:0];

  logic               va, vb;
  logic [63:0]        xs, xc, q0s, q0c;
  logic [SIDE_W+63:0] side_a;
  logic [SIDE_W+191:0] side_b;
  logic [63:0]        xs_b, xc_b, p2_b, rs, rc, qs, qc;
  logic               valid_q;
  logic [63:0]        p2_q, s_q, c_q;
  logic [SIDE_W-1:0]  side_q;

  // products p2*s and p2*c
  bmg_mul #(.SHIFT(62), .SIDE_W(SIDE_W + 64)) u_mul_s (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (valid_i),
    .a_i (p2_i), .b_i (s_i), .side_i ({p2_i, side_i}),
    .valid_o (va), .prod_o (xs), .side_o (side_a)
  );

  bmg_mul #(.SHIFT(62), .SIDE_W(1)) u_mul_c (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (valid_i),
    .a_i (p2_i), .b_i (c_i), .side_i (1'b0),
    .valid_o (), .prod_o (xc), .side_o ()
  );

  // quotient estimate by reciprocal, low by at most one
  bmg_mul #(.SHIFT(64), .SIDE_W(SIDE_W + 192)) u_div_s (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (va),
    .a_i (xs), .b_i (RECIP_S), .side_i ({xs, xc, side_a}),
    .valid_o (vb), .prod_o (q0s), .side_o (side_b)
  );

  bmg_mul #(.SHIFT(64), .SIDE_W(1)) u_div_c (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (va),
    .a_i (xc), .b_i (RECIP_C), .side_i (1'b0),
    .valid_o (), .prod_o (q0c), .side_o ()
  );

  assign xs_b = side_b[SIDE_W+191:SIDE_W+128];
  assign xc_b = side_b[SIDE_W+127:SIDE_W+64];
  assign p2_b = side_b[SIDE_W+63:SIDE_W];

  // remainder check and quotient fix
  assign rs = xs_b - q0s * DS;
  assign rc = xc_b - q0c * DC;
  assign qs = (rs >= DS) ? q0s + 64'd1 : q0s;
  assign qc = (rc >= DC) ? q0c + 64'd1 : q0c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vb;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_q   <= p2_b;
    s_q    <= ONE_Q62 - qs;
    c_q    <= ONE_Q62 - qc;
    side_q <= side_b[SIDE_W-1:0];
  end

  assign valid_o = valid_q;
  assign p2_o    = p2_q;
  assign s_o     = s_q;
  assign c_o     = c_q;
  assign side_o  = side_q;

endmodule

// File: src/box_muller_gaussian.sv
// channel | direction | handshake       | payload
// --------+-----------+-----------------+---------------------------------------
// input   | in        | start, busy     | in_i: uniform_a, uniform_b
// result  | out       | valid_o strobe  | out_o: normal_cos, normal_sin, bad_input
//
// one transaction per clock; busy is never raised, the pipeline takes an item every cycle
// the pipeline is a chain of cells: 56 squaring cells for log2, 60 square root cells,
// 11 Horner cells, plus the input, front, multiply and output stages
// reset clears only the valid bits of the pipeline, nothing is flushed afterwards
// the receiver cannot stall; every result is shown for exactly one cycle
module box_muller_gaussian (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bmg_pkg::bmg_in_t  in_i,
  output logic              valid_o,
  output bmg_pkg::bmg_out_t out_o
);
  import bmg_pkg::*;

  localparam int FRONT_W = $bits(bmg_front_t);
  localparam int RAD_W   = $bits(bmg_rad_t);
  localparam int HS_W    = $bits(bmg_hside_t);
  localparam int SIN_W   = $bits(bmg_sin_t);
  localparam int SGN_W   = $bits(bmg_sign_t);
  localparam int SH      = 56 - OUT_FRAC_BITS;

  // input register
  logic    in_v_q;
  bmg_in_t in_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_i;
  end

  // normalize u1 and fold the angle into an octant
  logic [TOP_W-1:0] top;
  logic [6:0]       msh;
  logic [63:0]      ang;
  logic [60:0]      fr;
  logic             fr_v_q;
  logic [63:0]      m0_q;
  bmg_front_t       front_d, front_q;

  always_comb begin
    top = '0;
    for (int i = 0; i < UNIFORM_BITS; i++) begin
      if (in_q.uniform_a[i]) begin
        top = TOP_W'(i);
      end
    end
  end

  assign msh = 7'd61 - 7'(top);
  assign ang = {in_q.uniform_b, (64 - UNIFORM_BITS)'(0)};
  assign fr  = ang[60:0];

  always_comb begin
    front_d.bad  = (in_q.uniform_a == '0);
    front_d.oct  = ang[63:61];
    front_d.f    = ang[61] ? ((62'd1 << 61) - {1'b0, fr}) : {1'b0, fr};
    front_d.expo = EXP_W'(UNIFORM_BITS) - EXP_W'(top);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_v_q <= 1'b0;
    end else begin
      fr_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m0_q    <= 64'(in_q.uniform_a) << msh;
    front_q <= front_d;
  end

  // log2 chain
  logic       lg_v    [0:LOG_STEPS];
  logic [63:0] lg_m   [0:LOG_STEPS];
  logic [55:0] lg_frac[0:LOG_STEPS];
  bmg_front_t lg_side [0:LOG_STEPS];

  assign lg_v[0]    = fr_v_q;
  assign lg_m[0]    = m0_q;
  assign lg_frac[0] = '0;
  assign lg_side[0] = front_q;

  generate
    for (genvar n = 0; n < LOG_STEPS; n++) begin : g_log
      bmg_log_cell #(.SIDE_W(FRONT_W)) u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni),
        .valid_i (lg_v[n]), .m_i (lg_m[n]), .frac_i (lg_frac[n]), .side_i (lg_side[n]),
        .valid_o (lg_v[n+1]), .m_o (lg_m[n+1]), .frac_o (lg_frac[n+1]),
        .side_o (lg_side[n+1])
      );
    end
  endgenerate

  // -2 ln u1 = log2 term times 2 ln 2
  logic [63:0] l2, r2;
  logic        r2_v;
  bmg_front_t  r2_side;

  assign l2 = (64'(lg_side[LOG_STEPS].expo) << 56) - 64'(lg_frac[LOG_STEPS]);

  bmg_mul #(.SHIFT(62), .SIDE_W(FRONT_W)) u_mul_ln (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (lg_v[LOG_STEPS]),
    .a_i (l2), .b_i (TWO_LN2_Q62), .side_i (lg_side[LOG_STEPS]),
    .valid_o (r2_v), .prod_o (r2), .side_o (r2_side)
  );

  // square root chain
  logic        rt_v   [0:ROOT_STEPS];
  logic [63:0] rt_x   [0:ROOT_STEPS];
  logic [63:0] rt_rem [0:ROOT_STEPS];
  logic [63:0] rt_root[0:ROOT_STEPS];
  bmg_front_t  rt_side[0:ROOT_STEPS];

  assign rt_v[0]    = r2_v;
  assign rt_x[0]    = r2;
  assign rt_rem[0]  = '0;
  assign rt_root[0] = '0;
  assign rt_side[0] = r2_side;

  generate
    for (genvar n = 0; n < ROOT_STEPS; n++) begin : g_root
      bmg_root_cell #(.IDX(ROOT_STEPS - 1 - n), .SIDE_W(FRONT_W)) u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni),
        .valid_i (rt_v[n]), .x_i (rt_x[n]), .rem_i (rt_rem[n]),
        .root_i (rt_root[n]), .side_i (rt_side[n]),
        .valid_o (rt_v[n+1]), .x_o (rt_x[n+1]), .rem_o (rt_rem[n+1]),
        .root_o (rt_root[n+1]), .side_o (rt_side[n+1])
      );
    end
  endgenerate

  // angle in radians and its square
  bmg_rad_t   rad_d, rad_phi;
  logic       phi_v, p2_v;
  logic [63:0] phi, p2;
  bmg_hside_t hs_p2;

  always_comb begin
    rad_d.bad = rt_side[ROOT_STEPS].bad;
    rad_d.oct = rt_side[ROOT_STEPS].oct;
    rad_d.r   = rt_root[ROOT_STEPS];
  end

  bmg_mul #(.SHIFT(62), .SIDE_W(RAD_W)) u_mul_phi (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (rt_v[ROOT_STEPS]),
    .a_i (64'(rt_side[ROOT_STEPS].f)), .b_i (PI_Q61), .side_i (rad_d),
    .valid_o (phi_v), .prod_o (phi), .side_o (rad_phi)
  );

  bmg_mul #(.SHIFT(62), .SIDE_W(HS_W)) u_mul_p2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (phi_v),
    .a_i (phi), .b_i (phi), .side_i ({rad_phi, phi}),
    .valid_o (p2_v), .prod_o (p2), .side_o (hs_p2)
  );

  // Horner chain for sine and cosine series
  logic        tg_v   [0:TAYLOR_TERMS];
  logic [63:0] tg_p2  [0:TAYLOR_TERMS];
  logic [63:0] tg_s   [0:TAYLOR_TERMS];
  logic [63:0] tg_c   [0:TAYLOR_TERMS];
  bmg_hside_t  tg_side[0:TAYLOR_TERMS];

  assign tg_v[0]    = p2_v;
  assign tg_p2[0]   = p2;
  assign tg_s[0]    = ONE_Q62;
  assign tg_c[0]    = ONE_Q62;
  assign tg_side[0] = hs_p2;

  generate
    for (genvar n = 0; n < TAYLOR_TERMS; n++) begin : g_trig
      bmg_trig_cell #(.K(TAYLOR_TERMS - n), .SIDE_W(HS_W)) u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni),
        .valid_i (tg_v[n]), .p2_i (tg_p2[n]), .s_i (tg_s[n]), .c_i (tg_c[n]),
        .side_i (tg_side[n]),
        .valid_o (tg_v[n+1]), .p2_o (tg_p2[n+1]), .s_o (tg_s[n+1]), .c_o (tg_c[n+1]),
        .side_o (tg_side[n+1])
      );
    end
  endgenerate

  // sine of the folded angle
  logic       sn_v;
  logic [63:0] sn;
  bmg_sin_t   sn_side;

  bmg_mul #(.SHIFT(62), .SIDE_W(SIN_W)) u_mul_sin (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (tg_v[TAYLOR_TERMS]),
    .a_i (tg_side[TAYLOR_TERMS].phi), .b_i (tg_s[TAYLOR_TERMS]),
    .side_i ({tg_side[TAYLOR_TERMS].rad, tg_c[TAYLOR_TERMS]}),
    .valid_o (sn_v), .prod_o (sn), .side_o (sn_side)
  );

  // octant symmetry: swap and signs
  logic [3:0]  oct_p1, oct_p2;
  logic        swap;
  logic [63:0] trig_c, trig_s;
  bmg_sign_t   sgn_d, sgn_q;
  logic        mc_v;
  logic [63:0] mag_c, mag_s;

  assign oct_p1 = {1'b0, sn_side.rad.oct} + 4'd1;
  assign oct_p2 = {1'b0, sn_side.rad.oct} + 4'd2;
  assign swap   = oct_p1[1];
  assign trig_c = swap ? sn : sn_side.c;
  assign trig_s = swap ? sn_side.c : sn;

  always_comb begin
    sgn_d.bad   = sn_side.rad.bad;
    sgn_d.neg_c = oct_p2[2];
    sgn_d.neg_s = sn_side.rad.oct[2];
  end

  // radius times trig value
  bmg_mul #(.SHIFT(62), .SIDE_W(SGN_W)) u_mul_oc (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sn_v),
    .a_i (sn_side.rad.r), .b_i (trig_c), .side_i (sgn_d),
    .valid_o (mc_v), .prod_o (mag_c), .side_o (sgn_q)
  );

  bmg_mul #(.SHIFT(62), .SIDE_W(1)) u_mul_os (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sn_v),
    .a_i (sn_side.rad.r), .b_i (trig_s), .side_i (1'b0),
    .valid_o (), .prod_o (mag_s), .side_o ()
  );

  // round half up, saturate, apply sign
  function automatic logic [OUT_W-1:0] to_out(input logic [63:0] v, input logic neg);
    logic [63:0] rv;
    logic [63:0] lim;
    rv  = (v + (64'd1 << (SH - 1))) >> SH;
    lim = (64'd1 << (OUT_W - 1)) - 64'd1;
    if (rv > lim) begin
      rv = lim;
    end
    if (neg) begin
      rv = 64'd0 - rv;
    end
    return rv[OUT_W-1:0];
  endfunction

  // output register
  logic     out_v_q;
  bmg_out_t out_d, out_q;

  always_comb begin
    if (sgn_q.bad) begin
      out_d.normal_cos = '0;
      out_d.normal_sin = '0;
      out_d.bad_input  = 1'b1;
    end else begin
      out_d.normal_cos = to_out(mag_c, sgn_q.neg_c);
      out_d.normal_sin = to_out(mag_s, sgn_q.neg_s);
      out_d.bad_input  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= mc_v;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = out_v_q;
  assign out_o   = out_q;

  // a flagged transaction carries zero samples
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.bad_input) |-> (out_q.normal_cos == '0 && out_q.normal_sin == '0))
    else $error("flagged result is not zero");

  // saturation is symmetric, the most negative code never appears
  a_cos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.normal_cos != {1'b1, (OUT_W - 1)'(0)}))
    else $error("cosine output below negative limit");

  a_sin_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.normal_sin != {1'b1, (OUT_W - 1)'(0)}))
    else $error("sine output below negative limit");

endmodule

// File: dv/box_muller_gaussian_checker.sv
module box_muller_gaussian_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  bmg_pkg::bmg_in_t  in_i,
  input  logic              valid_o,
  input  bmg_pkg::bmg_out_t out_o,
  output int                fail_count,
  output int                pending_count
);
  import bmg_pkg::*;

  bmg_out_t gauss_q[$];

  // truncated product (a*b) >> s on 128 bits
  function automatic logic [63:0] prod_shr(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = a * b;
    p = p >> s;
    return p[63:0];
  endfunction

  // -2 ln(u) in Q56 through log2 by repeated squaring
  function automatic logic [63:0] neg_two_ln(logic [UNIFORM_BITS-1:0] u);
    int top;
    logic [63:0] m, frac, l2;
    top = UNIFORM_BITS - 1;
    while (top > 0 && u[top] == 1'b0) top--;
    m = 64'(u) << (61 - top);
    frac = 0;
    for (int i = 0; i < LOG_STEPS; i++) begin
      m = prod_shr(m, m, 61);
      frac = frac << 1;
      if (m >= (64'd1 << 62)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    l2 = (64'(UNIFORM_BITS - top) << 56) - frac;
    return prod_shr(l2, TWO_LN2_Q62, 62);
  endfunction

  // restoring square root, Q56 in and out
  function automatic logic [63:0] radius_q56(logic [63:0] x);
    logic [63:0] rem, root, pair, trial;
    int j;
    rem = 0;
    root = 0;
    for (int i = ROOT_STEPS - 1; i >= 0; i--) begin
      j = 2 * i + 1 - 56;
      pair = (j >= 1) ? ((x >> (j - 1)) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // scale by trig value, round to output format, saturate and sign
  function automatic logic [OUT_W-1:0] scale_out(logic [63:0] r, logic [63:0] trig,
                                                 logic neg);
    int sh;
    logic [63:0] v, lim;
    sh = 56 - OUT_FRAC_BITS;
    lim = (64'd1 << (OUT_W - 1)) - 1;
    v = prod_shr(r, trig, 62);
    v = (v + (64'd1 << (sh - 1))) >> sh;
    if (v > lim) v = lim;
    if (neg) v = 64'd0 - v;
    return v[OUT_W-1:0];
  endfunction

  function automatic bmg_out_t gauss_pair(bmg_in_t x);
    bmg_out_t o;
    logic [63:0] a, f, phi, p2, s, c, sn, cs, r, t;
    logic [2:0] oct;
    o = '0;
    if (x.uniform_a == 0) begin
      o.bad_input = 1'b1;
      return o;
    end
    r = radius_q56(neg_two_ln(x.uniform_a));
    a = 64'(x.uniform_b) << (64 - UNIFORM_BITS);
    oct = a[63:61];
    f = {3'b0, a[60:0]};
    if (oct[0]) f = (64'd1 << 61) - f;
    phi = prod_shr(f, PI_Q61, 62);
    p2 = prod_shr(phi, phi, 62);
    s = ONE_Q62;
    c = ONE_Q62;
    for (int k = TAYLOR_TERMS; k >= 1; k--) begin
      s = ONE_Q62 - prod_shr(p2, s, 62) / 64'((2 * k) * (2 * k + 1));
      c = ONE_Q62 - prod_shr(p2, c, 62) / 64'((2 * k - 1) * (2 * k));
    end
    sn = prod_shr(phi, s, 62);
    cs = c;
    if (oct == 3'd1 || oct == 3'd2 || oct == 3'd5 || oct == 3'd6) begin
      t = sn;
      sn = cs;
      cs = t;
    end
    o.normal_cos = scale_out(r, cs, oct >= 3'd2 && oct <= 3'd5);
    o.normal_sin = scale_out(r, sn, oct[2]);
    return o;
  endfunction

  assign pending_count = gauss_q.size();

  // predict on accepted input, compare on strobe
  always @(posedge clk_i or negedge rst_ni) begin
    bmg_out_t want;
    if (!rst_ni) begin
      fail_count <= 0;
    end else begin
      if (valid_o) begin
        if (gauss_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_o);
          fail_count <= fail_count + 1;
        end else begin
          want = gauss_q.pop_front();
          if (want.normal_cos !== out_o.normal_cos || want.normal_sin !== out_o.normal_sin
              || want.bad_input !== out_o.bad_input) begin
            $display("%0t: mismatch expected cos %h sin %h bad %b, actual cos %h sin %h bad %b",
                     $time, want.normal_cos, want.normal_sin, want.bad_input,
                     out_o.normal_cos, out_o.normal_sin, out_o.bad_input);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) gauss_q.push_back(gauss_pair(in_i));
    end
  end
endmodule

// File: dv/box_muller_gaussian_tb.sv
module box_muller_gaussian_tb;
  import bmg_pkg::*;

  localparam int LATENCY  = 240;
  localparam int WD_LIMIT = 4000;

  logic     clk_i, rst_ni, start, busy, valid_o;
  bmg_in_t  in_i;
  bmg_out_t out_o;
  int       fail_count, pending_count;
  int       idle_cycles;

  box_muller_gaussian u_top (.*);

  box_muller_gaussian_checker u_chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog on cycles without a transaction
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("box_muller_gaussian_tb: FAIL");
      $finish;
    end
  end

  // present one pair and hold until accepted
  task automatic send_pair(logic [31:0] ua, logic [31:0] ub);
    start <= 1'b1;
    in_i  <= '{uniform_a: ua, uniform_b: ub};
    do @(posedge clk_i); while (busy);
  endtask

  task automatic maybe_gap(bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      in_i  <= '{uniform_a: $urandom, uniform_b: $urandom};
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_a();
    case ($urandom_range(0, 3))
      0: return $urandom >> $urandom_range(0, 31);
      1: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] edge_a[8];
    logic [31:0] edge_b[12];
    idle_cycles = 0;
    rst_ni = 1'b0;
    start  = 1'b0;
    in_i   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, tiny and full-scale u1 over octant boundaries
    edge_a = '{32'h0, 32'h1, 32'h2, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF,
               32'h5555_5555, 32'hAAAA_AAAA};
    edge_b = '{32'h0, 32'h2000_0000, 32'h4000_0000, 32'h6000_0000, 32'h8000_0000,
               32'hA000_0000, 32'hC000_0000, 32'hE000_0000, 32'hFFFF_FFFF,
               32'h1FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
    foreach (edge_a[i]) send_pair(edge_a[i], edge_b[i]);
    for (int i = 8; i < 12; i++) send_pair(32'h1, edge_b[i]);
    foreach (edge_b[i]) begin
      if (i < 8) send_pair(32'h4000_0000, edge_b[i]);
    end

    // hold off until the pipeline has drained
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);

    // random pairs, gaps early, back to back at the end
    for (int n = 0; n < 2000; n++) begin
      maybe_gap(n < 1600);
      send_pair(rand_a(), $urandom);
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (LATENCY / 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("box_muller_gaussian_tb: PASS");
    end else begin
      $display("box_muller_gaussian_tb: FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
src/bmg_pkg.sv
src/bmg_mul.sv
src/bmg_log_cell.sv
src/bmg_root_cell.sv
src/bmg_trig_cell.sv
src/box_muller_gaussian.sv
dv/box_muller_gaussian_checker.sv
dv/box_muller_gaussian_tb.sv
